@@ rtl/ascii_integer_parser_macros.svh @@
`ifndef ASCII_INTEGER_PARSER_MACROS_SVH
`define ASCII_INTEGER_PARSER_MACROS_SVH

// same-cycle implication, checked outside reset
`define AIP_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ascii_integer_parser check failed");

// next-cycle implication, checked outside reset
`define AIP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ascii_integer_parser check failed");

`endif

@@ rtl/aip_pkg.sv @@
`timescale 1ns / 1ps
package aip_pkg;

  localparam int unsigned VALUE_BITS_DEF = 64;
  localparam int unsigned VALUE_W        = 64;
  localparam int unsigned CHAR_W         = 8;
  localparam int unsigned USED_W         = 10;
  localparam int unsigned BASE_W         = 6;
  localparam int unsigned LIMIT_W        = 8;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 8;
  localparam int unsigned Q_DEPTH        = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_MODE = 2'd2;

  localparam logic [BASE_W-1:0]  BASE_RESET   = 6'd10;
  localparam logic [BASE_W-1:0]  BASE_AUTO    = 6'd0;
  localparam logic [BASE_W-1:0]  BASE_ONE     = 6'd1;
  localparam logic [BASE_W-1:0]  BASE_OCT     = 6'd8;
  localparam logic [BASE_W-1:0]  BASE_DEC     = 6'd10;
  localparam logic [BASE_W-1:0]  BASE_HEX     = 6'd16;
  localparam logic [BASE_W-1:0]  BASE_MAX     = 6'd36;
  localparam logic [LIMIT_W-1:0] DIGITS_MAX   = 8'hFF;
  localparam logic [USED_W-1:0]  USED_MAX     = 10'h3FF;

  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_X = 8'h78;
  localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_PLUS    = 8'h2B;
  localparam logic [CHAR_W-1:0] DIGIT_OFFSET = 8'd10;

  typedef struct packed {
    logic [BASE_W-1:0]  number_base;
    logic [LIMIT_W-1:0] digit_limit;
    logic               signed_mode;
  } cfg_t;

  // classified character as it sits in the queue
  typedef struct packed {
    logic              start;
    logic              is_minus;
    logic              is_plus;
    logic              is_zero;
    logic              is_x;
    logic              dig_ok;
    logic [BASE_W-1:0] dig;
  } entry_t;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_PREFIX = 4'b0010,
    PH_ZERO   = 4'b0100,
    PH_DIGITS = 4'b1000
  } phase_t;

  function automatic logic limit_hit(logic [LIMIT_W-1:0] lim, logic [LIMIT_W-1:0] cnt);
    return (lim != '0) && (cnt >= lim);
  endfunction

endpackage

@@ rtl/aip_in_if.sv @@
`timescale 1ns / 1ps
interface aip_in_if;
  logic                        valid;
  logic                        ready;
  logic [aip_pkg::CHAR_W-1:0]  char_code;
  logic                        start_flag;

  modport source (output valid, output char_code, output start_flag, input ready);
  modport sink   (input valid, input char_code, input start_flag, output ready);
endinterface

@@ rtl/aip_out_if.sv @@
`timescale 1ns / 1ps
interface aip_out_if;
  logic                        valid;
  logic                        ready;
  logic [aip_pkg::VALUE_W-1:0] parsed_value;
  logic                        parse_ok;
  logic [aip_pkg::USED_W-1:0]  chars_used;

  modport source (output valid, output parsed_value, output parse_ok, output chars_used,
                  input ready);
  modport sink   (input valid, input parsed_value, input parse_ok, input chars_used,
                  output ready);
endinterface

@@ rtl/aip_front.sv @@
`timescale 1ns / 1ps
module aip_front (
  input  logic            clk,
  input  logic            rst,
  aip_in_if.sink          in_ch,
  output aip_pkg::entry_t head,
  output logic            head_valid,
  input  logic            head_pop
);
  import aip_pkg::*;

  localparam int unsigned PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);

  entry_t             q_mem [Q_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  entry_t             cls;
  logic               push;
  logic [CHAR_W-1:0]  c;

  always_comb begin
    c            = in_ch.char_code;
    cls          = '0;
    cls.start    = in_ch.start_flag;
    cls.is_minus = (c == CHAR_MINUS);
    cls.is_plus  = (c == CHAR_PLUS);
    cls.is_zero  = (c == CHAR_ZERO);
    cls.is_x     = (c == CHAR_LOWER_X);
    if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
      cls.dig_ok = 1'b1;
      cls.dig    = BASE_W'(c - CHAR_ZERO);
    end else if (c inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
      cls.dig_ok = 1'b1;
      cls.dig    = BASE_W'(c - CHAR_LOWER_A + DIGIT_OFFSET);
    end else if (c inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
      cls.dig_ok = 1'b1;
      cls.dig    = BASE_W'(c - CHAR_UPPER_A + DIGIT_OFFSET);
    end
  end

  assign in_ch.ready = (count != CNT_W'(Q_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign head        = q_mem[rd_ptr];
  assign head_valid  = (count != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (head_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !head_pop) begin
        count <= count + 1'b1;
      end else if (!push && head_pop) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

@@ rtl/aip_back.sv @@
`timescale 1ns / 1ps
module aip_back #(
  parameter int unsigned VALUE_BITS = aip_pkg::VALUE_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  aip_pkg::cfg_t   cfg,
  input  aip_pkg::entry_t head,
  input  logic            head_valid,
  output logic            head_pop,
  aip_out_if.source       out_ch
);
  import aip_pkg::*;

  localparam int unsigned PROD_W = VALUE_BITS + BASE_W;

  function automatic logic [USED_W-1:0] used_inc(logic [USED_W-1:0] v);
    return (v == USED_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [LIMIT_W-1:0] dig_inc(logic [LIMIT_W-1:0] v);
    return (v == DIGITS_MAX) ? v : v + 1'b1;
  endfunction

  phase_t                phase, phase_next;
  logic [VALUE_BITS-1:0] acc, acc_next;
  logic [BASE_W-1:0]     base, base_next;
  logic                  minus, minus_next;
  logic [LIMIT_W-1:0]    dc, dc_next;
  logic [USED_W-1:0]     uc, uc_next;

  logic                  emit;
  logic [VALUE_BITS-1:0] res_value;
  logic                  res_ok;
  logic [USED_W-1:0]     res_used;
  logic                  cont;
  logic                  take;
  logic                  fin;
  logic [PROD_W-1:0]     prod;
  logic [VALUE_BITS-1:0] dig_term;

  logic                  out_valid;
  logic [VALUE_BITS-1:0] out_value;
  logic                  out_ok;
  logic [USED_W-1:0]     out_used;

  assign head_pop = head_valid && (!out_valid || out_ch.ready);

  always_comb begin
    phase_next = phase;
    acc_next   = acc;
    base_next  = base;
    minus_next = minus;
    dc_next    = dc;
    uc_next    = uc;
    emit       = 1'b0;
    res_value  = '0;
    res_ok     = 1'b0;
    res_used   = '0;
    cont       = 1'b1;
    take       = 1'b0;
    fin        = 1'b0;
    prod       = '0;
    dig_term   = '0;

    if (head.start) begin
      acc_next   = '0;
      minus_next = 1'b0;
      dc_next    = '0;
      uc_next    = '0;
      base_next  = cfg.number_base;
      if (cfg.number_base == BASE_ONE || cfg.number_base > BASE_MAX) begin
        // invalid radix fails right away
        base_next  = '0;
        emit       = 1'b1;
        res_value  = '1;
        phase_next = PH_IDLE;
        cont       = 1'b0;
      end else begin
        phase_next = PH_PREFIX;
        if (cfg.signed_mode && head.is_minus) begin
          minus_next = 1'b1;
          uc_next    = USED_W'(1);
          cont       = 1'b0;
        end else if (head.is_plus) begin
          uc_next = USED_W'(1);
          cont    = 1'b0;
        end
      end
    end

    if (cont) begin
      case (phase_next)
        PH_PREFIX: begin
          if ((base_next == BASE_AUTO || base_next == BASE_HEX) && head.is_zero) begin
            uc_next    = used_inc(uc_next);
            phase_next = PH_ZERO;
          end else begin
            if (base_next == BASE_AUTO) begin
              base_next = BASE_DEC;
            end
            phase_next = PH_DIGITS;
            take       = 1'b1;
          end
        end
        PH_ZERO: begin
          phase_next = PH_DIGITS;
          if (head.is_x) begin
            uc_next = used_inc(uc_next);
            if (base_next == BASE_AUTO) begin
              base_next = BASE_HEX;
            end
          end else begin
            // leading zero counts as a digit in hex, selects octal in auto mode
            if (base_next == BASE_AUTO) begin
              base_next = BASE_OCT;
            end else begin
              dc_next = LIMIT_W'(1);
            end
            take = 1'b1;
          end
        end
        PH_DIGITS: begin
          take = 1'b1;
        end
        default: begin
        end
      endcase
    end

    if (take) begin
      if (limit_hit(cfg.digit_limit, dc_next) || !head.dig_ok || head.dig >= base_next) begin
        fin = 1'b1;
      end else begin
        // negative runs accumulate the negated value directly
        dig_term = minus_next ? (~VALUE_BITS'(head.dig) + 1'b1) : VALUE_BITS'(head.dig);
        prod     = PROD_W'(acc_next) * PROD_W'(base_next);
        acc_next = prod[VALUE_BITS-1:0] + dig_term;
        dc_next  = dig_inc(dc_next);
        uc_next  = used_inc(uc_next);
        if (limit_hit(cfg.digit_limit, dc_next)) begin
          fin = 1'b1;
        end
      end
    end

    if (fin) begin
      emit       = 1'b1;
      phase_next = PH_IDLE;
      if (dc_next != '0) begin
        res_value = acc_next;
        res_ok    = 1'b1;
        res_used  = uc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      acc   <= '0;
      base  <= '0;
      minus <= 1'b0;
      dc    <= '0;
      uc    <= '0;
    end else if (head_pop) begin
      phase <= phase_next;
      acc   <= acc_next;
      base  <= base_next;
      minus <= minus_next;
      dc    <= dc_next;
      uc    <= uc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (head_pop && emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (head_pop && emit) begin
      out_value <= res_value;
      out_ok    <= res_ok;
      out_used  <= res_used;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.parsed_value = VALUE_W'(out_value);
  assign out_ch.parse_ok     = out_ok;
  assign out_ch.chars_used   = out_used;
endmodule

@@ rtl/ascii_integer_parser.sv @@
// ascii_integer_parser: parses one integer from a stream of ASCII characters
//
// in_ch carries one character per item (char_code, start_flag); start_flag
// opens a new number. out_ch carries at most one result per number
// (parsed_value, parse_ok, chars_used). Both use valid/ready.
// number_base, digit_limit and signed_mode are written through cfg_we,
// cfg_index and cfg_data; they are meant to change only while idle.
//
// Throughput: one character per cycle unless out_ch stalls. Each accepted digit is one
// step of the back-end multiply-add (accumulator times radix plus the digit, minus it when negative).
// out_ch.valid rises once the character that ends the number has passed the queue write
// and then the engine step into the result register.
// A two-entry queue sits between the classifier and the parse engine; when
// out_ch stalls the result register holds, the queue fills, and in_ch.ready
// drops once it is full.
// Reset (rst, synchronous) empties the queue and the result register, sets
// the registers to base 10, no digit limit, unsigned, and parks the parser
// until the next start character.
`timescale 1ns / 1ps
`include "ascii_integer_parser_macros.svh"
module ascii_integer_parser #(
  parameter int unsigned VALUE_BITS = aip_pkg::VALUE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  aip_in_if.sink                            in_ch,
  aip_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [aip_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [aip_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import aip_pkg::*;

  cfg_t   cfg;
  entry_t head;
  logic   head_valid;
  logic   head_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.number_base <= BASE_RESET;
      cfg.digit_limit <= '0;
      cfg.signed_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NUMBER_BASE: cfg.number_base <= cfg_data[BASE_W-1:0];
        CFG_DIGIT_LIMIT: cfg.digit_limit <= cfg_data[LIMIT_W-1:0];
        CFG_SIGNED_MODE: cfg.signed_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  aip_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .head       (head),
    .head_valid (head_valid),
    .head_pop   (head_pop)
  );

  aip_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .out_ch     (out_ch)
  );

  // engine never takes from an empty queue
  `AIP_ASSERT_NOW(a_pop_has_item, clk, rst, head_pop, head_valid)
  // a failed parse reports no consumed characters
  `AIP_ASSERT_NOW(a_fail_no_used, clk, rst, out_ch.valid && !out_ch.parse_ok,
                  out_ch.chars_used == '0)
  // a good parse consumed at least one character
  `AIP_ASSERT_NOW(a_ok_has_used, clk, rst, out_ch.valid && out_ch.parse_ok,
                  out_ch.chars_used != '0)
  // input backpressure only when the queue holds items
  `AIP_ASSERT_NOW(a_ready_low_full, clk, rst, !in_ch.ready, head_valid)
endmodule

@@ test/tb_ascii_integer_parser.sv @@
`timescale 1ns / 1ps
module tb_ascii_integer_parser;
  import aip_pkg::*;

  localparam int QUIET_LIMIT = 2000;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               ok;
    logic [USED_W-1:0]  used;
  } parse_result_t;

  class parse_scoreboard;
    cfg_t               regs;
    phase_t             phase;
    logic [VALUE_W-1:0] acc;
    logic [BASE_W-1:0]  radix;
    logic               minus;
    logic [LIMIT_W-1:0] ndigits;
    logic [USED_W-1:0]  nused;
    parse_result_t      expected_results[$];
    int                 n_checked;
    int                 n_errors;

    function new();
      regs.number_base = BASE_RESET;
      regs.digit_limit = '0;
      regs.signed_mode = 1'b0;
      phase            = PH_IDLE;
      acc              = '0;
      radix            = '0;
      minus            = 1'b0;
      ndigits          = '0;
      nused            = '0;
      n_checked        = 0;
      n_errors         = 0;
    endfunction

    function int char_value(logic [CHAR_W-1:0] c);
      if (c >= CHAR_ZERO && c <= CHAR_NINE) return int'(c - CHAR_ZERO);
      if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) return int'(c - CHAR_LOWER_A) + 10;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) return int'(c - CHAR_UPPER_A) + 10;
      return -1;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_NUMBER_BASE: regs.number_base = data[BASE_W-1:0];
        CFG_DIGIT_LIMIT: regs.digit_limit = data[LIMIT_W-1:0];
        CFG_SIGNED_MODE: regs.signed_mode = data[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function bit limit_reached();
      return regs.digit_limit != '0 && ndigits >= regs.digit_limit;
    endfunction

    function void emit(logic [VALUE_W-1:0] v, logic ok, logic [USED_W-1:0] used);
      parse_result_t r;
      r.value = v;
      r.ok    = ok;
      r.used  = used;
      expected_results.push_back(r);
      phase = PH_IDLE;
    endfunction

    function void close_number();
      if (ndigits == '0) emit('0, 1'b0, '0);
      else emit(minus ? (~acc + 1'b1) : acc, 1'b1, nused);
    endfunction

    function void bump_used();
      if (nused != USED_MAX) nused++;
    endfunction

    function void accumulate_digit(logic [CHAR_W-1:0] c);
      int d;
      if (limit_reached()) begin
        close_number();
        return;
      end
      d = char_value(c);
      // anything outside the radix ends the number and is not consumed
      if (d < 0 || d >= int'(radix)) begin
        close_number();
        return;
      end
      acc = acc * {{(VALUE_W-BASE_W){1'b0}}, radix} + VALUE_W'(d);
      if (ndigits != DIGITS_MAX) ndigits++;
      bump_used();
      if (limit_reached()) close_number();
    endfunction

    function void note_char(logic [CHAR_W-1:0] c, logic st);
      if (st) begin
        acc     = '0;
        minus   = 1'b0;
        ndigits = '0;
        nused   = '0;
        radix   = regs.number_base;
        if (radix == BASE_ONE || radix > BASE_MAX) begin
          radix = '0;
          emit('1, 1'b0, '0);
          return;
        end
        phase = PH_PREFIX;
        if (regs.signed_mode && c == CHAR_MINUS) begin
          minus = 1'b1;
          nused = USED_W'(1);
          return;
        end
        if (c == CHAR_PLUS) begin
          nused = USED_W'(1);
          return;
        end
      end
      case (phase)
        PH_PREFIX: begin
          if ((radix == BASE_AUTO || radix == BASE_HEX) && c == CHAR_ZERO) begin
            bump_used();
            phase = PH_ZERO;
          end else begin
            if (radix == BASE_AUTO) radix = BASE_DEC;
            phase = PH_DIGITS;
            accumulate_digit(c);
          end
        end
        PH_ZERO: begin
          phase = PH_DIGITS;
          if (c == CHAR_LOWER_X) begin
            bump_used();
            if (radix == BASE_AUTO) radix = BASE_HEX;
          end else begin
            // auto base: leading zero means octal; hex: the zero counts as a digit
            if (radix == BASE_AUTO) radix = BASE_OCT;
            else ndigits = LIMIT_W'(1);
            accumulate_digit(c);
          end
        end
        PH_DIGITS: accumulate_digit(c);
        default: ;
      endcase
    endfunction

    function void report_error(string msg);
      n_errors++;
      if (n_errors <= 10) $display("ERROR: %s", msg);
    endfunction

    function void check_result(logic [VALUE_W-1:0] v, logic ok, logic [USED_W-1:0] used);
      parse_result_t e;
      if (expected_results.size() == 0) begin
        report_error($sformatf("result %h ok %0b used %0d with nothing pending", v, ok, used));
        return;
      end
      e = expected_results.pop_front();
      n_checked++;
      if (v !== e.value)
        report_error($sformatf("parsed_value exp %h got %h", e.value, v));
      if (ok !== e.ok)
        report_error($sformatf("parse_ok exp %0b got %0b (value %h)", e.ok, ok, e.value));
      if (used !== e.used)
        report_error($sformatf("chars_used exp %0d got %0d (value %h)", e.used, used, e.value));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  aip_in_if  in_ch();
  aip_out_if out_ch();

  ascii_integer_parser i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  parse_scoreboard   sb;
  int                quiet_cycles = 0;
  int                chars_driven = 0;
  int                burst_left   = 0;
  int                n_settings   = 0;
  logic [BASE_W-1:0] cur_base;
  int                rx_tick      = 0;
  int                rx_mode      = 0;
  int                stall_left   = 0;

  // results are checked before the same-edge item is noted
  always @(posedge clk) begin
    if (!rst) begin
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.parsed_value, out_ch.parse_ok, out_ch.chars_used);
      if (in_ch.valid && in_ch.ready)
        sb.note_char(in_ch.char_code, in_ch.start_flag);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  // receiver: always ready, random drops, or long stalls, in a mode picked anew at random
  always @(negedge clk) begin
    rx_tick++;
    if (rx_tick % 256 == 0) rx_mode = $urandom_range(0, 2);
    case (rx_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          out_ch.ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
          stall_left = $urandom_range(1, 30);
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    endcase
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(negedge clk);
    $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
    $display("tb_ascii_integer_parser NOT OK");
    $finish;
  end

  task automatic send_char(input logic [CHAR_W-1:0] c, input logic st);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 24) : $urandom_range(0, 3);
      repeat (gap) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.char_code  <= c;
    in_ch.start_flag <= st;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
    chars_driven++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == 0);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(input logic [BASE_W-1:0] b, input logic [LIMIT_W-1:0] lim,
                          input logic sm);
    wait_idle();
    write_reg(CFG_NUMBER_BASE, CFG_DATA_W'(b));
    write_reg(CFG_DIGIT_LIMIT, lim);
    write_reg(CFG_SIGNED_MODE, CFG_DATA_W'(sm));
    cur_base = b;
    n_settings++;
  endtask

  function automatic logic [CHAR_W-1:0] digit_char(int d);
    if (d < 10) return CHAR_ZERO + CHAR_W'(d);
    return ($urandom_range(0, 1) ? CHAR_LOWER_A : CHAR_UPPER_A) + CHAR_W'(d - 10);
  endfunction

  // sign, prefix, digits of the radix, then usually a terminator and some trailing junk
  task automatic send_number();
    logic [CHAR_W-1:0] txt[$];
    logic [CHAR_W-1:0] c;
    int                radix;
    int                ndig;
    int                r;
    radix = (cur_base == BASE_ONE || cur_base > BASE_MAX) ? 10 : int'(cur_base);
    r = $urandom_range(0, 3);
    if (r == 0) txt.push_back(CHAR_MINUS);
    else if (r == 1) txt.push_back(CHAR_PLUS);
    if (radix == 0 || radix == 16) begin
      r = $urandom_range(0, 3);
      if (r == 0) begin
        txt.push_back(CHAR_ZERO);
        txt.push_back(CHAR_LOWER_X);
        radix = 16;
      end else if (r == 1) begin
        txt.push_back(CHAR_ZERO);
        if (radix == 0) radix = 8;
      end else if (radix == 0) begin
        radix = 10;
      end
    end
    r = $urandom_range(0, 9);
    ndig = (r == 0) ? 0 : (r < 8) ? $urandom_range(1, 6) : $urandom_range(10, 24);
    for (int i = 0; i < ndig; i++)
      txt.push_back(digit_char(($urandom_range(0, 3) == 0) ? radix - 1
                                                          : $urandom_range(0, radix - 1)));
    if ($urandom_range(0, 6) != 0) begin
      c = CHAR_W'($urandom_range(0, 255));
      while (sb.char_value(c) >= 0 && sb.char_value(c) < radix)
        c = CHAR_W'($urandom_range(0, 255));
      txt.push_back(c);
      repeat ($urandom_range(0, 2)) txt.push_back(CHAR_W'($urandom_range(0, 255)));
    end
    foreach (txt[i]) send_char(txt[i], i == 0);
  endtask

  initial begin
    int               phase_end;
    logic [BASE_W-1:0] b;
    logic [LIMIT_W-1:0] lim;
    sb = new();
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    in_ch.valid      = 1'b0;
    in_ch.char_code  = '0;
    in_ch.start_flag = 1'b0;
    out_ch.ready     = 1'b0;
    cur_base         = BASE_RESET;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: defaults, then auto base with sign, invalid base, limits
    send_text("+12;");
    send_text("-,");
    set_regs(BASE_AUTO, 8'd0, 1'b1);
    send_text("-0x1F.");
    send_text("017 ");
    send_text("0 ");
    set_regs(BASE_MAX + 6'd1, 8'd0, 1'b0);
    send_text("5");
    set_regs(BASE_MAX, 8'd2, 1'b0);
    send_text("zZ9");
    set_regs(BASE_HEX, 8'd1, 1'b0);
    send_text("07");

    // long run: the widest digit limit
    set_regs(BASE_MAX, DIGITS_MAX, 1'b1);
    send_char(CHAR_MINUS, 1'b1);
    for (int i = 0; i < 257; i++) send_char(digit_char($urandom_range(0, 35)), 1'b0);

    while (chars_driven < 950) begin
      case ($urandom_range(0, 11))
        0:  b = BASE_AUTO;
        1:  b = 6'd2;
        2:  b = BASE_OCT;
        3:  b = BASE_DEC;
        4:  b = BASE_HEX;
        5:  b = BASE_MAX;
        6:  b = BASE_ONE;
        7:  b = BASE_MAX + 6'd1;
        8:  b = 6'h3F;
        9:  b = BASE_AUTO;
        10: b = BASE_HEX;
        default: b = BASE_W'($urandom_range(0, 63));
      endcase
      case ($urandom_range(0, 8))
        0, 1, 2: lim = 8'd0;
        3: lim = 8'd1;
        4: lim = 8'd2;
        5: lim = 8'd3;
        6: lim = DIGITS_MAX;
        default: lim = LIMIT_W'($urandom_range(0, 255));
      endcase
      set_regs(b, lim, 1'($urandom_range(0, 1)));
      phase_end = chars_driven + $urandom_range(30, 90);
      while (chars_driven < phase_end) begin
        if ($urandom_range(0, 7) == 0) begin
          for (int i = $urandom_range(1, 6); i > 0; i--)
            send_char(CHAR_W'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end else begin
          send_number();
        end
      end
    end

    wait_idle();
    repeat (8) @(negedge clk);
    for (int i = sb.pending(); i > 0; i--) sb.report_error("expected result never arrived");
    $display("%0d characters sent under %0d register settings", chars_driven, n_settings);
    $display("%0d parse results checked, %0d mismatches", sb.n_checked, sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("tb_ascii_integer_parser OK");
    end else begin
      $display("tb_ascii_integer_parser NOT OK");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/aip_pkg.sv
rtl/aip_in_if.sv
rtl/aip_out_if.sv
rtl/aip_front.sv
rtl/aip_back.sv
rtl/ascii_integer_parser.sv
test/tb_ascii_integer_parser.sv
